// ===== rtl/core/timestamp_stream_merger_unit_defines.svh =====
// Assertion macros shared by the timestamp stream merger RTL.
`ifndef TIMESTAMP_STREAM_MERGER_UNIT_DEFINES_SVH
`define TIMESTAMP_STREAM_MERGER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define TSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TSM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define TSM_ASSERT(lbl, prop, msg)
`define TSM_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/core/tsm_pkg.sv =====
// Shared types and constants of the timestamp stream merger.
package tsm_pkg;

  localparam int unsigned TIME_W     = 48;
  localparam int unsigned PAYLOAD_W  = 16;
  localparam int unsigned SRC_PORT_W = 2;
  localparam int unsigned LIMIT_W    = 5;

  localparam logic [LIMIT_W-1:0] RESULT_LIMIT = 5'd16;

  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]    cmd_time;
    logic [PAYLOAD_W-1:0] payload;
  } cmd_word_t;

  typedef struct packed {
    logic clear;
    logic cmp;
  } pick_ctl_t;

endpackage

// ===== rtl/core/timestamp_stream_merger_unit.sv =====
// Top level of the timestamp stream merger: limit register, store, comparator, sequencer.
// A push is taken only while idle; pushes are taken back to back and busy stays low.
// A flush of stored commands holds busy while it runs one scan of the source heads per
// merged command; an empty flush leaves busy low.
// With S commands trimmed, the S oldest are merged but not transferred. Reset clears counts,
// drop flag and strobe and sets the limit to 16.
`include "timestamp_stream_merger_unit_defines.svh"

module timestamp_stream_merger_unit import tsm_pkg::*; #(
  parameter int unsigned NUM_SOURCES = 4,
  parameter int unsigned MAX_CMDS    = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  action_i,
  input  logic [SRC_PORT_W-1:0] source_i,
  input  logic [TIME_W-1:0]     cmd_time_i,
  input  logic [PAYLOAD_W-1:0]  cmd_payload_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [LIMIT_W-1:0]    cfg_data_i,
  output logic                  out_valid_o,
  output logic [TIME_W-1:0]     out_time_o,
  output logic [PAYLOAD_W-1:0]  out_payload_o,
  output logic [SRC_PORT_W-1:0] out_source_o,
  output logic                  out_last_o,
  output logic                  out_dropped_o
);

  localparam int unsigned DEPTH = NUM_SOURCES * MAX_CMDS;
  localparam int unsigned SW    = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(MAX_CMDS + 1);
  localparam int unsigned TW    = $clog2(DEPTH + 1);

  logic [LIMIT_W-1:0] limit_q;
  logic               we;
  logic [AW-1:0]      waddr;
  logic               re;
  logic [AW-1:0]      raddr;
  cmd_word_t          wdata;
  cmd_word_t          rdata;
  pick_ctl_t          pick_ctl;
  logic [SW-1:0]      rd_src;
  logic               found;
  logic [SW-1:0]      best_src;
  cmd_word_t          best_word;

  assign cfg_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= RESULT_LIMIT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  assign wdata.cmd_time = cmd_time_i;
  assign wdata.payload  = cmd_payload_i;

  tsm_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  tsm_pick #(
    .SW(SW)
  ) u_pick (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (pick_ctl),
    .src_i      (rd_src),
    .word_i     (rdata),
    .found_o    (found),
    .best_src_o (best_src),
    .best_word_o(best_word)
  );

  tsm_ctrl #(
    .NUM_SOURCES(NUM_SOURCES),
    .MAX_CMDS   (MAX_CMDS),
    .SW         (SW),
    .AW         (AW),
    .CW         (CW),
    .TW         (TW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .action_i     (action_i),
    .src_i        (source_i),
    .limit_i      (limit_q),
    .busy_o       (busy),
    .we_o         (we),
    .waddr_o      (waddr),
    .re_o         (re),
    .raddr_o      (raddr),
    .pick_ctl_o   (pick_ctl),
    .rd_src_o     (rd_src),
    .found_i      (found),
    .best_src_i   (best_src),
    .best_word_i  (best_word),
    .out_valid_o  (out_valid_o),
    .out_time_o   (out_time_o),
    .out_payload_o(out_payload_o),
    .out_source_o (out_source_o),
    .out_last_o   (out_last_o),
    .out_dropped_o(out_dropped_o)
  );

  `TSM_ASSERT(a_run_busy, out_valid_o && !out_last_o |-> busy, "Merge ended before its final result.")
  `TSM_ASSERT(a_last_idle, out_valid_o && out_last_o |-> !busy, "Busy after the final result.")
  `TSM_ASSERT_NEVER(a_strobe_gap, out_valid_o && $past(out_valid_o), "Result strobes back to back.")

endmodule

// ===== rtl/core/tsm_store.sv =====
// Command store: one write port and one registered read port.
module tsm_store import tsm_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  cmd_word_t     wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output cmd_word_t     rdata_o
);

  cmd_word_t mem_q [DEPTH];
  cmd_word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tsm_pick.sv =====
// Shared comparator that keeps the oldest source head seen during a scan.
module tsm_pick import tsm_pkg::*; #(
  parameter int unsigned SW = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pick_ctl_t     ctl_i,
  input  logic [SW-1:0] src_i,
  input  cmd_word_t     word_i,
  output logic          found_o,
  output logic [SW-1:0] best_src_o,
  output cmd_word_t     best_word_o
);

  logic          found_q;
  logic [SW-1:0] best_src_q;
  cmd_word_t     best_word_q;
  logic          take;

  // Later sources win on equal times, so the compare is inclusive.
  assign take = ctl_i.cmp && !ctl_i.clear &&
                (!found_q || (word_i.cmd_time <= best_word_q.cmd_time));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.clear) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_src_q  <= src_i;
      best_word_q <= word_i;
    end
  end

  assign found_o     = found_q;
  assign best_src_o  = best_src_q;
  assign best_word_o = best_word_q;

endmodule

// ===== rtl/core/tsm_ctrl.sv =====
// Sequencer: source buffer bookkeeping, head scan, trimming and result registers.
module tsm_ctrl import tsm_pkg::*; #(
  parameter int unsigned NUM_SOURCES = 4,
  parameter int unsigned MAX_CMDS    = 16,
  parameter int unsigned SW          = 2,
  parameter int unsigned AW          = 6,
  parameter int unsigned CW          = 5,
  parameter int unsigned TW          = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  action_i,
  input  logic [SRC_PORT_W-1:0] src_i,
  input  logic [LIMIT_W-1:0]    limit_i,
  output logic                  busy_o,
  output logic                  we_o,
  output logic [AW-1:0]         waddr_o,
  output logic                  re_o,
  output logic [AW-1:0]         raddr_o,
  output pick_ctl_t             pick_ctl_o,
  output logic [SW-1:0]         rd_src_o,
  input  logic                  found_i,
  input  logic [SW-1:0]         best_src_i,
  input  cmd_word_t             best_word_i,
  output logic                  out_valid_o,
  output logic [TIME_W-1:0]     out_time_o,
  output logic [PAYLOAD_W-1:0]  out_payload_o,
  output logic [SRC_PORT_W-1:0] out_source_o,
  output logic                  out_last_o,
  output logic                  out_dropped_o
);

  localparam int unsigned SCW = $clog2(NUM_SOURCES + 1);
  localparam int unsigned XW  = (TW > LIMIT_W) ? TW : LIMIT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_PICK = 2'd2;

  logic [1:0]     state_q, state_d;
  logic [SCW-1:0] scan_q, scan_d;
  logic [CW-1:0]  counts_q [NUM_SOURCES];
  logic [CW-1:0]  counts_d [NUM_SOURCES];
  logic [CW-1:0]  heads_q [NUM_SOURCES];
  logic [CW-1:0]  heads_d [NUM_SOURCES];
  logic [TW-1:0]  total_q, total_d;
  logic [TW-1:0]  skip_q, skip_d;
  logic           drop_q, drop_d;
  logic           push_drop_q, push_drop_d;
  logic           rd_live_q, rd_live_d;
  logic [SW-1:0]  rd_src_q, rd_src_d;

  logic                  out_valid_q;
  logic [TIME_W-1:0]     out_time_q;
  logic [PAYLOAD_W-1:0]  out_payload_q;
  logic [SRC_PORT_W-1:0] out_source_q;
  logic                  out_last_q;
  logic                  out_dropped_q;

  logic               accept;
  logic               src_ok;
  logic [SW-1:0]      push_idx;
  logic [CW-1:0]      push_cnt;
  logic               push_ok;
  logic               issue;
  logic [SW-1:0]      scan_idx;
  logic               live;
  logic [LIMIT_W-1:0] lim_eff;
  logic               over;
  logic               emit;
  logic               last;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign src_ok   = (32'(src_i) < NUM_SOURCES);
  assign push_idx = src_ok ? SW'(src_i) : '0;
  assign push_cnt = counts_q[push_idx];
  assign push_ok  = accept && (action_i == ACT_PUSH) && src_ok && (32'(push_cnt) < MAX_CMDS);

  assign issue    = (state_q == ST_SCAN) && (32'(scan_q) < NUM_SOURCES);
  assign scan_idx = issue ? scan_q[SW-1:0] : '0;
  assign live     = (counts_q[scan_idx] != '0);

  assign we_o    = push_ok;
  assign waddr_o = AW'(32'(push_idx) * MAX_CMDS + 32'(push_cnt));
  assign re_o    = issue && live;
  assign raddr_o = AW'(32'(scan_idx) * MAX_CMDS + 32'(heads_q[scan_idx]));

  always_comb begin
    if (limit_i == '0) begin
      lim_eff = LIMIT_W'(1);
    end else if (limit_i > RESULT_LIMIT) begin
      lim_eff = RESULT_LIMIT;
    end else begin
      lim_eff = limit_i;
    end
  end

  assign over = (XW'(total_q) > XW'(lim_eff));
  assign last = (total_q == TW'(1));

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    counts_d    = counts_q;
    heads_d     = heads_q;
    total_d     = total_q;
    skip_d      = skip_q;
    drop_d      = drop_q;
    push_drop_d = push_drop_q;
    rd_live_d   = 1'b0;
    rd_src_d    = rd_src_q;
    emit        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (action_i == ACT_PUSH) begin
            if (push_ok) begin
              counts_d[push_idx] = push_cnt + CW'(1);
              total_d            = total_q + TW'(1);
            end else begin
              push_drop_d = 1'b1;
            end
          end else begin
            push_drop_d = 1'b0;
            drop_d      = push_drop_q || over;
            skip_d      = over ? TW'(XW'(total_q) - XW'(lim_eff)) : '0;
            if (total_q != '0) begin
              state_d = ST_SCAN;
              scan_d  = '0;
            end
          end
        end
      end
      ST_SCAN: begin
        rd_live_d = re_o;
        rd_src_d  = scan_idx;
        scan_d    = scan_q + SCW'(1);
        if (32'(scan_q) == NUM_SOURCES) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        if (found_i) begin
          heads_d[best_src_i]  = heads_q[best_src_i] + CW'(1);
          counts_d[best_src_i] = counts_q[best_src_i] - CW'(1);
          total_d              = total_q - TW'(1);
          if (skip_q != '0) begin
            skip_d = skip_q - TW'(1);
          end else begin
            emit = 1'b1;
          end
          if (last) begin
            state_d = ST_IDLE;
            heads_d = '{default: '0};
          end else begin
            state_d = ST_SCAN;
            scan_d  = '0;
          end
        end else begin
          state_d = ST_IDLE;
          heads_d = '{default: '0};
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      counts_q    <= '{default: '0};
      heads_q     <= '{default: '0};
      total_q     <= '0;
      skip_q      <= '0;
      drop_q      <= 1'b0;
      push_drop_q <= 1'b0;
      rd_live_q   <= 1'b0;
      rd_src_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      counts_q    <= counts_d;
      heads_q     <= heads_d;
      total_q     <= total_d;
      skip_q      <= skip_d;
      drop_q      <= drop_d;
      push_drop_q <= push_drop_d;
      rd_live_q   <= rd_live_d;
      rd_src_q    <= rd_src_d;
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_time_q    <= best_word_i.cmd_time;
      out_payload_q <= best_word_i.payload;
      out_source_q  <= SRC_PORT_W'(best_src_i);
      out_last_q    <= last;
      out_dropped_q <= drop_q;
    end
  end

  assign busy_o           = (state_q != ST_IDLE);
  assign pick_ctl_o.clear = (state_q == ST_PICK);
  assign pick_ctl_o.cmp   = rd_live_q;
  assign rd_src_o         = rd_src_q;

  assign out_valid_o   = out_valid_q;
  assign out_time_o    = out_time_q;
  assign out_payload_o = out_payload_q;
  assign out_source_o  = out_source_q;
  assign out_last_o    = out_last_q;
  assign out_dropped_o = out_dropped_q;

endmodule
